// ----- rtl/ptrs_pkg.sv -----
// shared types and constants for the point table search unit
`default_nettype none

package ptrs_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 6;
    localparam int RAD_W    = 23;
    localparam int DIST_W   = 50;
    localparam int TAG_ID_W = 10;

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RADIUS  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd3;

    typedef struct packed {
        logic                vld;
        logic                last;
        logic                ok;
        logic [TAG_ID_W-1:0] id;
    } scan_tag_t;

endpackage

`default_nettype wire

// ----- rtl/ptrs_mem.sv -----
// point position memory, one write port and one registered read port
`default_nettype none

module ptrs_mem
    import ptrs_pkg::*;
#(
    parameter int NODE_COUNT = 64,
    parameter int COORD_BITS = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  wire logic signed [COORD_BITS-1:0]  wr_x,
    input  wire logic signed [COORD_BITS-1:0]  wr_y,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
    output logic signed [COORD_BITS-1:0]       rd_x,
    output logic signed [COORD_BITS-1:0]       rd_y
);

    logic [2*COORD_BITS-1:0] mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en)
        begin
            {rd_x, rd_y} <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ptrs_dist.sv -----
// three stage squared distance pipeline with saturation
`default_nettype none

module ptrs_dist
    import ptrs_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire scan_tag_t                    tag_in,
    input  wire logic signed [COORD_BITS-1:0] pt_x,
    input  wire logic signed [COORD_BITS-1:0] pt_y,
    input  wire logic signed [COORD_BITS-1:0] q_x,
    input  wire logic signed [COORD_BITS-1:0] q_y,
    output scan_tag_t                         tag_out,
    output logic [DIST_W-1:0]                 dist_out
);

    localparam int AW    = COORD_BITS + 1;
    localparam int SQ_W  = 2 * AW;
    localparam int SUM_W = SQ_W + 1;

    logic signed [AW-1:0] dx;
    logic signed [AW-1:0] dy;
    logic [AW-1:0]        ax_next;
    logic [AW-1:0]        ay_next;
    logic [AW-1:0]        ax_reg;
    logic [AW-1:0]        ay_reg;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;
    logic [SUM_W-1:0]     sum;
    logic [DIST_W-1:0]    dist_next;
    scan_tag_t            t1_reg;
    scan_tag_t            t2_reg;

    assign dx      = $signed({pt_x[COORD_BITS-1], pt_x}) - $signed({q_x[COORD_BITS-1], q_x});
    assign dy      = $signed({pt_y[COORD_BITS-1], pt_y}) - $signed({q_y[COORD_BITS-1], q_y});
    assign ax_next = dx[AW-1] ? AW'(-dx) : AW'(dx);
    assign ay_next = dy[AW-1] ? AW'(-dy) : AW'(dy);
    assign sum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    generate
        if (SUM_W > DIST_W)
        begin : g_sat
            assign dist_next = (|sum[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
        end
        else
        begin : g_nosat
            assign dist_next = DIST_W'(sum);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            tag_out <= '0;
        end
        else
        begin
            t1_reg  <= tag_in;
            t2_reg  <= t1_reg;
            tag_out <= t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        dist_out <= dist_next;
    end

endmodule

`default_nettype wire

// ----- rtl/point_table_radius_nearest_search_unit.sv -----
// top level: point table, scan controller and result register
//
// channel | direction | fields
// req     | in        | mode, node_id, coord_x, coord_y, search_radius
// rsp     | out       | found, result_id, dist_squared, last
//
// clear and insert go from accept to ST_EMIT, which sends one ack word and returns to idle;
// a nearest search runs one full table scan and then sends one word
// a radius search with n matches sends max(n, 1) words, one full
// table scan through the memory read port and the distance pipeline per word sent
// reset empties the table at once through the per-entry valid flops
// req_stall is high while an item is in work; a stalled rsp word holds the next emit
// step but not the scan that runs behind it
`default_nettype none

module point_table_radius_nearest_search_unit
    import ptrs_pkg::*;
#(
    parameter int NODE_COUNT = 64,
    parameter int COORD_BITS = 24
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic [ID_W-1:0]              node_id,
    input  wire logic signed [COORD_BITS-1:0] coord_x,
    input  wire logic signed [COORD_BITS-1:0] coord_y,
    input  wire logic [RAD_W-1:0]             search_radius,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic                              found,
    output logic [ID_W-1:0]                   result_id,
    output logic [DIST_W-1:0]                 dist_squared,
    output logic                              last
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int KEY_W = DIST_W + IDX_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic signed [COORD_BITS-1:0] qx_reg, qx_next;
    logic signed [COORD_BITS-1:0] qy_reg, qy_next;
    logic [2*RAD_W-1:0]      r2_reg, r2_next;
    logic                    have_prev_reg, have_prev_next;
    logic [KEY_W-1:0]        prev_key_reg, prev_key_next;
    logic                    have_best_reg, have_best_next;
    logic [KEY_W-1:0]        best_key_reg, best_key_next;
    logic                    have_sec_reg, have_sec_next;
    logic [KEY_W-1:0]        sec_key_reg, sec_key_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    issue_reg, issue_next;
    logic                    rsp_valid_next;
    logic                    found_next;
    logic [ID_W-1:0]         result_id_next;
    logic [DIST_W-1:0]       dist_next;
    logic                    last_next;
    logic [NODE_COUNT-1:0]   valid_reg;
    scan_tag_t               tag0;
    scan_tag_t               tag1_reg;
    scan_tag_t               cmp_tag;
    logic [DIST_W-1:0]       cmp_dist;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic                    req_fire;
    logic                    id_ok;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [KEY_W-1:0]        cand_key;
    logic                    in_range;
    logic                    eligible;
    logic                    out_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign id_ok     = (32'(node_id) < NODE_COUNT);
    assign wr_addr   = IDX_W'(node_id);
    assign wr_en     = req_fire && (mode == MODE_INSERT) && id_ok;
    assign out_free  = !rsp_valid || !rsp_stall;

    assign tag0.vld  = issue_reg;
    assign tag0.last = (32'(idx_reg) == NODE_COUNT - 1);
    assign tag0.ok   = valid_reg[idx_reg];
    assign tag0.id   = TAG_ID_W'(idx_reg);

    ptrs_mem #(
        .NODE_COUNT (NODE_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_x    (coord_x),
        .wr_y    (coord_y),
        .rd_en   (issue_reg),
        .rd_addr (idx_reg),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    ptrs_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag1_reg),
        .pt_x     (rd_x),
        .pt_y     (rd_y),
        .q_x      (qx_reg),
        .q_y      (qy_reg),
        .tag_out  (cmp_tag),
        .dist_out (cmp_dist)
    );

    assign cand_key = {cmp_dist, cmp_tag.id[IDX_W-1:0]};
    assign in_range = (mode_reg == MODE_NEAREST) || (cmp_dist <= DIST_W'(r2_reg));
    assign eligible = cmp_tag.vld && cmp_tag.ok && in_range
                      && (!have_prev_reg || (cand_key > prev_key_reg));

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        r2_next        = r2_reg;
        have_prev_next = have_prev_reg;
        prev_key_next  = prev_key_reg;
        have_best_next = have_best_reg;
        best_key_next  = best_key_reg;
        have_sec_next  = have_sec_reg;
        sec_key_next   = sec_key_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        rsp_valid_next = rsp_valid && rsp_stall;
        found_next     = found;
        result_id_next = result_id;
        dist_next      = dist_squared;
        last_next      = last;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    mode_next      = mode;
                    qx_next        = coord_x;
                    qy_next        = coord_y;
                    r2_next        = search_radius * search_radius;
                    have_prev_next = 1'b0;
                    have_best_next = 1'b0;
                    have_sec_next  = 1'b0;
                    idx_next       = '0;
                    if (mode inside {MODE_RADIUS, MODE_NEAREST})
                    begin
                        issue_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (tag0.last)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (eligible)
                begin
                    if (!have_best_reg || (cand_key < best_key_reg))
                    begin
                        have_sec_next  = have_best_reg;
                        sec_key_next   = best_key_reg;
                        have_best_next = 1'b1;
                        best_key_next  = cand_key;
                    end
                    else if (!have_sec_reg || (cand_key < sec_key_reg))
                    begin
                        have_sec_next = 1'b1;
                        sec_key_next  = cand_key;
                    end
                end
                if (cmp_tag.vld && cmp_tag.last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = have_best_reg;
                    result_id_next = have_best_reg ? ID_W'(best_key_reg[IDX_W-1:0]) : '0;
                    dist_next      = have_best_reg ? best_key_reg[KEY_W-1:IDX_W] : '0;
                    last_next      = !(have_best_reg && have_sec_reg
                                       && (mode_reg == MODE_RADIUS));
                    if (have_best_reg && have_sec_reg && (mode_reg == MODE_RADIUS))
                    begin
                        have_prev_next = 1'b1;
                        prev_key_next  = best_key_reg;
                        have_best_next = 1'b0;
                        have_sec_next  = 1'b0;
                        idx_next       = '0;
                        issue_next     = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_CLEAR;
            qx_reg        <= '0;
            qy_reg        <= '0;
            r2_reg        <= '0;
            have_prev_reg <= 1'b0;
            prev_key_reg  <= '0;
            have_best_reg <= 1'b0;
            best_key_reg  <= '0;
            have_sec_reg  <= 1'b0;
            sec_key_reg   <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            tag1_reg      <= '0;
            valid_reg     <= '0;
            rsp_valid     <= 1'b0;
            found         <= 1'b0;
            result_id     <= '0;
            dist_squared  <= '0;
            last          <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            qx_reg        <= qx_next;
            qy_reg        <= qy_next;
            r2_reg        <= r2_next;
            have_prev_reg <= have_prev_next;
            prev_key_reg  <= prev_key_next;
            have_best_reg <= have_best_next;
            best_key_reg  <= best_key_next;
            have_sec_reg  <= have_sec_next;
            sec_key_reg   <= sec_key_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            tag1_reg      <= tag0;
            rsp_valid     <= rsp_valid_next;
            found         <= found_next;
            result_id     <= result_id_next;
            dist_squared  <= dist_next;
            last          <= last_next;
            if (req_fire && (mode == MODE_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // an empty or ack word carries no id or distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !found) |-> (result_id == '0 && dist_squared == '0 && last))
        else $error("empty word with payload");

    // scan data only flows while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_tag.vld |-> (state_reg == ST_SCAN))
        else $error("scan tag outside scan");

    // second best never beats best
    assert property (@(posedge clk) disable iff (!rst_n)
        (have_sec_reg && have_best_reg) |-> (best_key_reg < sec_key_reg))
        else $error("best and second out of order");

    // an accepted item always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE))
        else $error("item accepted without work");

endmodule

`default_nettype wire
